[design/sblc_pkg.sv]
// ----------------------------------------------------------------------------
// sblc_pkg: shared types, constants and tables for spectrum_bin_log_colormap
// Holds the log2 mantissa table, the decibel scale factor and the hue
// wheel helper.
// ----------------------------------------------------------------------------
package sblc_pkg;

    // Configuration register indexes
    typedef enum logic [7:0] {
        CFG_OFFSET = 8'd0,
        CFG_SLOPE  = 8'd1
    } t_cfg_idx;

    // 20*log10(2) in Q16
    localparam logic signed [19:0] DB_K_Q16 = 20'sd394566;

    localparam logic [11:0] HUE_SPAN    = 12'd1530;
    localparam logic [11:0] HUE_MID     = 12'd765;
    localparam logic [11:0] PHASE_RED   = 12'd0;
    localparam logic [11:0] PHASE_GREEN = 12'd1020;
    localparam logic [11:0] PHASE_BLUE  = 12'd510;

    localparam logic [7:0] EXP_SPECIAL = 8'hFF;

    typedef logic [9:0] t_log_table [256];

    // Pass-through payload
    typedef struct packed {
        logic [9:0] index;
        logic       last;
    } t_tag;

    // Forced result class
    typedef struct packed {
        logic zero;
        logic full;
    } t_cls;

    // log2(1 + i/256) in Q10, by bit-serial squaring of a Q30 value
    function automatic logic [9:0] log2_frac_q10(input int unsigned i);
        logic [63:0] x;
        logic [10:0] r;
        logic [11:0] rr;
        x = 64'(256 + (i & 255)) << 22;
        r = '0;
        for (int n = 0; n < 11; n++) begin
            x = (x * x) >> 30;
            r = {r[9:0], 1'b0};
            if (x >= 64'h8000_0000) begin
                r[0] = 1'b1;
                x    = x >> 1;
            end
        end
        rr = {1'b0, r} + 12'd1;
        return rr[10:1];
    endfunction

    function automatic t_log_table build_log_table();
        t_log_table t;
        for (int k = 0; k < 256; k++) begin
            t[k] = log2_frac_q10(k);
        end
        return t;
    endfunction

    localparam t_log_table LOG2_TABLE = build_log_table();

    // One component of the hue wheel
    function automatic logic [7:0] hue_comp(input logic [7:0] lvl, input logic [11:0] phase);
        logic [11:0] x;
        logic [11:0] d;
        x = 12'({lvl, 2'b00}) + 12'({lvl, 1'b0}) + phase;
        if (x >= HUE_SPAN) begin
            x = x - HUE_SPAN;
        end
        d = (x >= HUE_MID) ? (x - HUE_MID) : (HUE_MID - x);
        if (d <= 12'd255) begin
            return 8'd0;
        end else if (d >= 12'd510) begin
            return 8'd255;
        end else begin
            d = d - 12'd255;
            return d[7:0];
        end
    endfunction

endpackage

[design/spectrum_bin_log_colormap.sv]
// ----------------------------------------------------------------------------
// spectrum_bin_log_colormap: decibel level and hue colour of one spectrum bin
// Six-stage pipeline from IEEE single magnitude to level and RGB.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries a magnitude as IEEE single
//   bits, the bin index and a last-bin flag. Output channel (o_out_valid /
//   i_out_ready) returns pixel index, level, red, green, blue and column end,
//   one result per input, in order.
//   Config channel (i_cfg_valid / o_cfg_ready) writes offset_q8 (index 0) or
//   slope_q8 (index 1); other indexes are dropped. Write only while idle.
//   Throughput: one item per cycle while the receiver accepts results, set by
//   the six-stage pipeline (classify, normalize and table lookup, two
//   multiplies, offset add and saturate, hue).
//   Each stage advances when it is empty or the stage after it advances, so
//   bubbles collapse and input is taken while a result waits at the output.
//   Reset clears all stage valid bits and loads offset 20.0 and slope 1.0.
//   A stalled receiver holds the output register; the pipeline fills behind it.
// ----------------------------------------------------------------------------
module spectrum_bin_log_colormap (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_magnitude_bits,
    input  logic [9:0]  i_bin_index,
    input  logic        i_last_bin,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [9:0]  o_pixel_index,
    output logic [7:0]  o_level,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue,
    output logic        o_column_end,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import sblc_pkg::*;

    localparam int NSTG = 6;

    // Configuration
    logic signed [15:0] r_offset_q8;
    logic [11:0]        r_slope_q8;

    // Stage control
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] stg_adv;

    // Stage 1: classify, find leading one
    t_tag        r_s1_tag;
    t_cls        r_s1_cls;
    logic        r_s1_sub;
    logic [7:0]  r_s1_exp;
    logic [22:0] r_s1_mant;
    logic [4:0]  r_s1_lead;
    t_cls        n_s1_cls;
    logic [4:0]  n_s1_lead;

    // Stage 2: log2 in Q10
    t_tag               r_s2_tag;
    t_cls               r_s2_cls;
    logic signed [18:0] r_s2_l2;
    logic [22:0]        s2_shifted;
    logic [7:0]         s2_tidx;
    logic signed [8:0]  s2_exp;

    // Stage 3: times slope
    t_tag               r_s3_tag;
    t_cls               r_s3_cls;
    logic signed [31:0] r_s3_prod;

    // Stage 4: times decibel constant
    t_tag               r_s4_tag;
    t_cls               r_s4_cls;
    logic signed [51:0] r_s4_prod;

    // Stage 5: offset, floor, saturate
    t_tag               r_s5_tag;
    logic [7:0]         r_s5_level;
    logic signed [51:0] n_sum;
    logic signed [17:0] s5_floor;
    logic [7:0]         n_s5_level;

    // Stage 6: output register
    t_tag       r_s6_tag;
    logic [7:0] r_s6_level;
    logic [7:0] r_s6_red;
    logic [7:0] r_s6_green;
    logic [7:0] r_s6_blue;

    // ---------------- configuration ----------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset_q8 <= 16'sd5120;
            r_slope_q8  <= 12'd256;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_OFFSET: r_offset_q8 <= $signed(i_cfg_data);
                CFG_SLOPE:  r_slope_q8  <= i_cfg_data[11:0];
                default: ;
            endcase
        end
    end

    // ---------------- stage control ----------------
    always_comb begin
        stg_adv[NSTG-1] = !r_vld[NSTG-1] || i_out_ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            stg_adv[k] = !r_vld[k] || stg_adv[k+1];
        end
    end

    assign o_in_ready = stg_adv[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (stg_adv[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (stg_adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // ---------------- stage 1 ----------------
    always_comb begin
        n_s1_cls = '0;
        if (i_magnitude_bits[30:23] == EXP_SPECIAL) begin
            if (i_magnitude_bits[22:0] != '0) begin
                n_s1_cls.zero = 1'b1;
            end else if (i_magnitude_bits[31]) begin
                n_s1_cls.zero = 1'b1;
            end else begin
                n_s1_cls.full = 1'b1;
            end
        end else if (i_magnitude_bits[31]) begin
            n_s1_cls.zero = 1'b1;
        end else if (i_magnitude_bits[30:0] == '0) begin
            n_s1_cls.zero = 1'b1;
        end
        // highest set mantissa bit wins
        n_s1_lead = '0;
        for (int k = 0; k < 23; k++) begin
            if (i_magnitude_bits[k]) begin
                n_s1_lead = 5'(k);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (stg_adv[0]) begin
            r_s1_tag  <= '{index: i_bin_index, last: i_last_bin};
            r_s1_cls  <= n_s1_cls;
            r_s1_sub  <= (i_magnitude_bits[30:23] == 8'd0);
            r_s1_exp  <= i_magnitude_bits[30:23];
            r_s1_mant <= i_magnitude_bits[22:0];
            r_s1_lead <= n_s1_lead;
        end
    end

    // ---------------- stage 2 ----------------
    always_comb begin
        s2_shifted = r_s1_mant << (5'd23 - r_s1_lead);
        if (r_s1_sub) begin
            s2_tidx = s2_shifted[22:15];
            s2_exp  = $signed({4'b0, r_s1_lead}) - 9'sd149;
        end else begin
            s2_tidx = r_s1_mant[22:15];
            s2_exp  = $signed({1'b0, r_s1_exp}) - 9'sd127;
        end
    end

    always_ff @(posedge i_clk) begin
        if (stg_adv[1]) begin
            r_s2_tag <= r_s1_tag;
            r_s2_cls <= r_s1_cls;
            r_s2_l2  <= $signed({s2_exp, LOG2_TABLE[s2_tidx]});
        end
    end

    // ---------------- stage 3 ----------------
    always_ff @(posedge i_clk) begin
        if (stg_adv[2]) begin
            r_s3_tag  <= r_s2_tag;
            r_s3_cls  <= r_s2_cls;
            r_s3_prod <= 32'(r_s2_l2 * $signed({1'b0, r_slope_q8}));
        end
    end

    // ---------------- stage 4 ----------------
    always_ff @(posedge i_clk) begin
        if (stg_adv[3]) begin
            r_s4_tag  <= r_s3_tag;
            r_s4_cls  <= r_s3_cls;
            r_s4_prod <= 52'(r_s3_prod * DB_K_Q16);
        end
    end

    // ---------------- stage 5 ----------------
    always_comb begin
        n_sum    = r_s4_prod + 52'($signed({r_offset_q8, 26'b0}));
        // upper bits of a two's complement value give the floor
        s5_floor = n_sum[51:34];
        if (r_s4_cls.full) begin
            n_s5_level = 8'd255;
        end else if (r_s4_cls.zero || s5_floor < 0) begin
            n_s5_level = 8'd0;
        end else if (s5_floor > 18'sd255) begin
            n_s5_level = 8'd255;
        end else begin
            n_s5_level = s5_floor[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (stg_adv[4]) begin
            r_s5_tag   <= r_s4_tag;
            r_s5_level <= n_s5_level;
        end
    end

    // ---------------- stage 6 ----------------
    always_ff @(posedge i_clk) begin
        if (stg_adv[5]) begin
            r_s6_tag   <= r_s5_tag;
            r_s6_level <= r_s5_level;
            r_s6_red   <= hue_comp(r_s5_level, PHASE_RED);
            r_s6_green <= hue_comp(r_s5_level, PHASE_GREEN);
            r_s6_blue  <= hue_comp(r_s5_level, PHASE_BLUE);
        end
    end

    assign o_out_valid   = r_vld[NSTG-1];
    assign o_pixel_index = r_s6_tag.index;
    assign o_column_end  = r_s6_tag.last;
    assign o_level       = r_s6_level;
    assign o_red         = r_s6_red;
    assign o_green       = r_s6_green;
    assign o_blue        = r_s6_blue;

`ifndef SYNTH
    // An empty output stage always makes room upstream
    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input not ready while output stage is empty");

    // Hue wheel keeps one component at zero
    a_hue_one_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_red == 8'd0 || o_green == 8'd0 || o_blue == 8'd0))
        else $error("hue colour has no zero component");

    // Reset empties the pipeline
    a_reset_clears: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("output valid right after reset");
`endif

endmodule
